// ----- rtl/core/hbwd_pkg.sv -----
// ----------------------------------------------------------------------------
// hbwd_pkg
// Shared types, codes and the microcode table of the heartbeat watchdog.
// ----------------------------------------------------------------------------
package hbwd_pkg;

	localparam int CHANNELS = 6;

	localparam int CH_W   = 3;
	localparam int TICK_W = 32;
	localparam int PC_W   = 4;

	// input kinds
	localparam logic KIND_BEAT = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	// recovery actions
	localparam logic [1:0] ACT_RESTART = 2'd0;
	localparam logic [1:0] ACT_REINIT  = 2'd1;
	localparam logic [1:0] ACT_REBOOT  = 2'd2;
	localparam logic [1:0] ACT_NONE    = 2'd3;

	// system states
	localparam logic [1:0] ST_HEALTHY  = 2'd0;
	localparam logic [1:0] ST_NERVOUS  = 2'd1;
	localparam logic [1:0] ST_CRITICAL = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
	localparam logic [2:0] CFG_ESC      = 3'd1;
	localparam logic [2:0] CFG_RESTART  = 3'd2;
	localparam logic [2:0] CFG_REINIT   = 3'd3;
	localparam logic [2:0] CFG_EXEMPT   = 3'd4;

	localparam logic [31:0] TIMEOUT_RST = 32'd3000;
	localparam logic [7:0]  ESC_RST     = 8'd3;
	localparam logic [7:0]  RESTART_RST = 8'd1;
	localparam logic [7:0]  REINIT_RST  = 8'd2;
	localparam logic [7:0]  EXEMPT_RST  = 8'd24;

	typedef struct packed {
		logic              kind;
		logic [CH_W-1:0]   channel;
		logic [TICK_W-1:0] tick;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] target_channel;
		logic [1:0]      action;
		logic [7:0]      retry_level;
		logic [1:0]      system_state;
		logic [7:0]      fault_flags;
		logic            last;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_EVAL,
		OP_MISS,
		OP_ESC,
		OP_HEAL,
		OP_NEXT,
		OP_STATUS
	} op_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_SKIP,
		C_IN_TIME,
		C_BELOW_ESC,
		C_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic skip;
		logic in_time;
		logic below_esc;
		logic more;
		logic out_busy;
	} seq_flags_t;

	typedef struct packed {
		logic busy;
		logic fire;
		op_t  op;
	} seq_ctl_t;

	localparam logic [PC_W-1:0] PC_EVAL   = 4'd0;
	localparam logic [PC_W-1:0] PC_HEAL   = 4'd6;
	localparam logic [PC_W-1:0] PC_NEXT   = 4'd7;
	localparam logic [PC_W-1:0] PC_STATUS = 4'd8;

	// Scan program, one pass per channel. Jump taken when cond holds,
	// otherwise fall through to the next word.
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			4'd0:    w = '{OP_EVAL,   C_NONE,      PC_NEXT};
			4'd1:    w = '{OP_NOP,    C_SKIP,      PC_NEXT};
			4'd2:    w = '{OP_NOP,    C_IN_TIME,   PC_HEAL};
			4'd3:    w = '{OP_MISS,   C_NONE,      PC_NEXT};
			4'd4:    w = '{OP_NOP,    C_BELOW_ESC, PC_NEXT};
			4'd5:    w = '{OP_ESC,    C_ALWAYS,    PC_NEXT};
			4'd6:    w = '{OP_HEAL,   C_NONE,      PC_NEXT};
			4'd7:    w = '{OP_NEXT,   C_MORE,      PC_EVAL};
			4'd8:    w = '{OP_STATUS, C_ALWAYS,    PC_EVAL};
			default: w = '{OP_STATUS, C_ALWAYS,    PC_EVAL};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/heartbeat_watchdog_escalation.sv -----
// ----------------------------------------------------------------------------
// heartbeat_watchdog_escalation
// Multi-channel heartbeat watchdog with escalating recovery commands.
// ----------------------------------------------------------------------------
//  channel | signals                         | beat
//  in      | in_valid, in_ready, in_data     | heartbeat write or scan request
//  out     | out_valid, out_ready, out_data  | recovery command or scan status
//  cfg     | cfg_valid, cfg_ready, cfg_index,| register write, always ready
//          | cfg_data                        |
//
//  A heartbeat write is accepted while the sequencer is idle and gives no result.
//  A scan runs the microcode once per channel, with fewer steps for a skipped
//  channel than for one that escalates, then a single status step; no new
//  input is accepted until the status step has fired.
//  Output backpressure holds the sequencer on a result step.
//  Reset clears all channel state and loads the register defaults.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_escalation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hbwd_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hbwd_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	logic [31:0] timeout_q;
	logic [7:0]  esc_q;
	logic [7:0]  restart_q;
	logic [7:0]  reinit_q;
	logic [7:0]  exempt_q;

	logic [31:0] beat_q  [8];
	logic [7:0]  miss_q  [8];
	logic [7:0]  retry_q [8];
	logic [7:0]  flags_q;
	logic [1:0]  state_q;

	logic [31:0]                 tick_q;
	logic [hbwd_pkg::CH_W-1:0]   ch_q;
	logic                        over_q;
	logic                        skip_q;
	logic                        any_fault_q;

	logic                        out_valid_q;
	hbwd_pkg::out_item_t         out_q;

	hbwd_pkg::seq_flags_t        flags;
	hbwd_pkg::seq_ctl_t          ctl;

	logic        in_acc;
	logic        start;
	logic        emit;
	logic [31:0] cur_beat;
	logic [7:0]  cur_miss;
	logic [7:0]  cur_retry;
	logic [31:0] age;
	logic [7:0]  retry_inc;
	logic [1:0]  esc_action;
	logic [1:0]  esc_state;
	logic [1:0]  end_state;
	logic [7:0]  ch_bit;

	assign cfg_ready = 1'b1;
	assign in_ready  = !ctl.busy;
	assign in_acc    = in_valid && in_ready;
	assign start     = in_acc && (in_data.kind == hbwd_pkg::KIND_SCAN);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign emit      = ctl.fire &&
		(ctl.op == hbwd_pkg::OP_ESC || ctl.op == hbwd_pkg::OP_STATUS);

	always_comb begin
		cur_beat  = beat_q[ch_q];
		cur_miss  = miss_q[ch_q];
		cur_retry = retry_q[ch_q];
		ch_bit    = 8'd1 << ch_q;
		age       = tick_q - cur_beat;
		retry_inc = (cur_retry == 8'hFF) ? cur_retry : cur_retry + 8'd1;
		if (retry_inc <= restart_q) begin
			esc_action = hbwd_pkg::ACT_RESTART;
			esc_state  = hbwd_pkg::ST_NERVOUS;
		end else if (retry_inc <= reinit_q) begin
			esc_action = hbwd_pkg::ACT_REINIT;
			esc_state  = hbwd_pkg::ST_CRITICAL;
		end else begin
			esc_action = hbwd_pkg::ACT_REBOOT;
			esc_state  = hbwd_pkg::ST_CRITICAL;
		end
		end_state = (!any_fault_q && state_q == hbwd_pkg::ST_NERVOUS) ?
			hbwd_pkg::ST_HEALTHY : state_q;

		flags.skip      = skip_q;
		flags.in_time   = !over_q;
		flags.below_esc = cur_miss < esc_q;
		flags.more      = ch_q != hbwd_pkg::CH_W'(hbwd_pkg::CHANNELS - 1);
		flags.out_busy  = out_valid_q && !out_ready;
	end

	hbwd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctl    (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= hbwd_pkg::TIMEOUT_RST;
			esc_q       <= hbwd_pkg::ESC_RST;
			restart_q   <= hbwd_pkg::RESTART_RST;
			reinit_q    <= hbwd_pkg::REINIT_RST;
			exempt_q    <= hbwd_pkg::EXEMPT_RST;
			for (int i = 0; i < 8; i++) begin
				beat_q[i]  <= '0;
				miss_q[i]  <= '0;
				retry_q[i] <= '0;
			end
			flags_q     <= '0;
			state_q     <= hbwd_pkg::ST_HEALTHY;
			ch_q        <= '0;
			any_fault_q <= 1'b0;
			over_q      <= 1'b0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					hbwd_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
					hbwd_pkg::CFG_ESC:     esc_q     <= cfg_data[7:0];
					hbwd_pkg::CFG_RESTART: restart_q <= cfg_data[7:0];
					hbwd_pkg::CFG_REINIT:  reinit_q  <= cfg_data[7:0];
					hbwd_pkg::CFG_EXEMPT:  exempt_q  <= cfg_data[7:0];
					default: ;
				endcase
			end

			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (in_acc) begin
				if (in_data.kind == hbwd_pkg::KIND_BEAT) begin
					if (32'(in_data.channel) < 32'(hbwd_pkg::CHANNELS))
						beat_q[in_data.channel] <= in_data.tick;
				end else begin
					ch_q        <= '0;
					any_fault_q <= 1'b0;
				end
			end

			if (ctl.fire) begin
				unique case (ctl.op)
					hbwd_pkg::OP_NOP: ;
					hbwd_pkg::OP_EVAL: begin
						over_q <= age > timeout_q;
						skip_q <= exempt_q[ch_q] || (cur_beat == '0);
					end
					hbwd_pkg::OP_MISS: begin
						any_fault_q <= 1'b1;
						if (cur_miss != 8'hFF)
							miss_q[ch_q] <= cur_miss + 8'd1;
						// first miss raises the flag
						if (cur_miss == 8'd0)
							flags_q <= flags_q | ch_bit;
					end
					hbwd_pkg::OP_ESC: begin
						retry_q[ch_q] <= retry_inc;
						miss_q[ch_q]  <= '0;
						state_q       <= esc_state;
						out_q         <= '{ch_q, esc_action, retry_inc, esc_state,
							flags_q, 1'b0};
					end
					hbwd_pkg::OP_HEAL: begin
						if (flags_q[ch_q]) begin
							flags_q       <= flags_q & ~ch_bit;
							miss_q[ch_q]  <= '0;
							retry_q[ch_q] <= '0;
						end
					end
					hbwd_pkg::OP_NEXT: ch_q <= ch_q + 1'b1;
					hbwd_pkg::OP_STATUS: begin
						state_q     <= end_state;
						out_q       <= '{'0, hbwd_pkg::ACT_NONE, 8'd0, end_state,
							flags_q, 1'b1};
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.kind == hbwd_pkg::KIND_SCAN)
			tick_q <= in_data.tick;
	end

endmodule

// ----- rtl/core/hbwd_seq.sv -----
// ----------------------------------------------------------------------------
// hbwd_seq
// Microcode sequencer: step counter, table fetch and conditional jumps.
// ----------------------------------------------------------------------------
module hbwd_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  hbwd_pkg::seq_flags_t flags,
	output hbwd_pkg::seq_ctl_t   ctl
);

	logic                        busy_q;
	logic [hbwd_pkg::PC_W-1:0]   pc_q;
	hbwd_pkg::uword_t            uw;
	logic                        cond_true;
	logic                        stall;

	always_comb begin
		uw = hbwd_pkg::ucode(pc_q);
		unique case (uw.cond)
			hbwd_pkg::C_NONE:      cond_true = 1'b0;
			hbwd_pkg::C_ALWAYS:    cond_true = 1'b1;
			hbwd_pkg::C_SKIP:      cond_true = flags.skip;
			hbwd_pkg::C_IN_TIME:   cond_true = flags.in_time;
			hbwd_pkg::C_BELOW_ESC: cond_true = flags.below_esc;
			hbwd_pkg::C_MORE:      cond_true = flags.more;
			default:               cond_true = 1'b0;
		endcase
		// result-producing steps hold while the output register is full
		stall = (uw.op == hbwd_pkg::OP_ESC || uw.op == hbwd_pkg::OP_STATUS) && flags.out_busy;
		ctl.busy = busy_q;
		ctl.op   = uw.op;
		ctl.fire = busy_q && !stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= hbwd_pkg::PC_EVAL;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= hbwd_pkg::PC_EVAL;
		end else if (busy_q && !stall) begin
			if (uw.op == hbwd_pkg::OP_STATUS)
				busy_q <= 1'b0;
			pc_q <= cond_true ? uw.target : pc_q + 1'b1;
		end
	end

endmodule

// ----- verif/tb_heartbeat_watchdog_escalation.sv -----
// ----------------------------------------------------------------------------
// tb_heartbeat_watchdog_escalation
// Self-checking bench for the heartbeat watchdog. A directed table covers
// reset values, ignored channels, miss counting, every recovery action, healing
// and tick wraparound. Randomized phases follow under several register settings,
// ending with a long run that pushes one channel's retry count past both limits.
// All results are scored against a cycle-free behavioral predictor.
// ----------------------------------------------------------------------------
module tb_heartbeat_watchdog_escalation;
	timeunit 1ns;
	timeprecision 1ps;

	import hbwd_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 7 * CHANNELS + 8;
	localparam int CFG_SLOTS     = 8;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t status;
	} stim_row_t;

	typedef struct {
		logic [31:0] timeout;
		logic [7:0]  esc;
		logic [7:0]  restart;
		logic [7:0]  reinit;
		logic [7:0]  exempt;
		int          items;
		bit          saturate;
	} watch_setting_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// tag travelling with the input beat: typed status for directed rows
	bit        row_typed = 1'b0;
	out_item_t row_status = '0;

	// predictor state
	logic [31:0] timeout_r = TIMEOUT_RST;
	logic [7:0]  esc_r     = ESC_RST;
	logic [7:0]  restart_r = RESTART_RST;
	logic [7:0]  reinit_r  = REINIT_RST;
	logic [7:0]  exempt_r  = EXEMPT_RST;
	logic [31:0] beat_tick [8] = '{default: '0};
	logic [7:0]  miss_cnt [8]  = '{default: '0};
	logic [7:0]  retry_cnt [8] = '{default: '0};
	logic [7:0]  flags_r = '0;
	logic [1:0]  state_r = ST_HEALTHY;

	out_item_t pending_reports [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        tx_calm = 1'b0;
	bit        rx_calm = 1'b0;
	int        rx_hold = 0;
	int        rx_mode_left = 0;

	heartbeat_watchdog_escalation DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic out_item_t status_report(logic [1:0] st, logic [7:0] flags);
		out_item_t rep;
		rep.target_channel = '0;
		rep.action         = ACT_NONE;
		rep.retry_level    = '0;
		rep.system_state   = st;
		rep.fault_flags    = flags;
		rep.last           = 1'b1;
		return rep;
	endfunction

	function automatic stim_row_t beat_row(logic [CH_W-1:0] ch, logic [31:0] tick);
		stim_row_t row;
		row.item   = '{kind: KIND_BEAT, channel: ch, tick: tick};
		row.typed  = 1'b0;
		row.status = '0;
		return row;
	endfunction

	function automatic stim_row_t scan_row(logic [31:0] tick);
		stim_row_t row;
		row.item   = '{kind: KIND_SCAN, channel: '0, tick: tick};
		row.typed  = 1'b0;
		row.status = '0;
		return row;
	endfunction

	function automatic stim_row_t checked_scan(logic [31:0] tick, logic [1:0] st,
			logic [7:0] flags);
		stim_row_t row;
		row        = scan_row(tick);
		row.typed  = 1'b1;
		row.status = status_report(st, flags);
		return row;
	endfunction

	// Behavioral watchdog: updates channel state and queues the scan's beats.
	task automatic advance_watchdog(input in_item_t it);
		logic [7:0]  ch_bit;
		logic [31:0] age;
		logic [1:0]  act;
		bit          any_miss;
		out_item_t   rep;
		any_miss = 1'b0;
		if (it.kind == KIND_BEAT) begin
			if (it.channel < CHANNELS) beat_tick[it.channel] = it.tick;
			return;
		end
		for (int ch = 0; ch < CHANNELS; ch++) begin
			ch_bit = 8'(1) << ch;
			if ((exempt_r & ch_bit) != 0 || beat_tick[ch] == 0) continue;
			age = it.tick - beat_tick[ch];
			if (age > timeout_r) begin
				any_miss = 1'b1;
				if (miss_cnt[ch] != 8'hFF) miss_cnt[ch]++;
				if (miss_cnt[ch] == 8'd1) flags_r |= ch_bit;
				if (miss_cnt[ch] >= esc_r) begin
					if (retry_cnt[ch] != 8'hFF) retry_cnt[ch]++;
					if (retry_cnt[ch] <= restart_r) begin
						state_r = ST_NERVOUS;
						act = ACT_RESTART;
					end else if (retry_cnt[ch] <= reinit_r) begin
						state_r = ST_CRITICAL;
						act = ACT_REINIT;
					end else begin
						state_r = ST_CRITICAL;
						act = ACT_REBOOT;
					end
					rep.target_channel = ch[CH_W-1:0];
					rep.action         = act;
					rep.retry_level    = retry_cnt[ch];
					rep.system_state   = state_r;
					rep.fault_flags    = flags_r;
					rep.last           = 1'b0;
					pending_reports.push_back(rep);
					miss_cnt[ch] = '0;
				end
			end else if ((flags_r & ch_bit) != 0) begin
				flags_r &= ~ch_bit;
				miss_cnt[ch]  = '0;
				retry_cnt[ch] = '0;
			end
		end
		if (!any_miss && state_r == ST_NERVOUS) state_r = ST_HEALTHY;
		pending_reports.push_back(status_report(state_r, flags_r));
	endtask

	task automatic check_report(input out_item_t want, input out_item_t got);
		bit bad;
		bad = 1'b0;
		if (got.target_channel !== want.target_channel) begin
			$error("target_channel: expected %0d, got %0d", want.target_channel,
				got.target_channel);
			bad = 1'b1;
		end
		if (got.action !== want.action) begin
			$error("action: expected %0d, got %0d", want.action, got.action);
			bad = 1'b1;
		end
		if (got.retry_level !== want.retry_level) begin
			$error("retry_level: expected %0d, got %0d", want.retry_level,
				got.retry_level);
			bad = 1'b1;
		end
		if (got.system_state !== want.system_state) begin
			$error("system_state: expected %0d, got %0d", want.system_state,
				got.system_state);
			bad = 1'b1;
		end
		if (got.fault_flags !== want.fault_flags) begin
			$error("fault_flags: expected 0x%02h, got 0x%02h", want.fault_flags,
				got.fault_flags);
			bad = 1'b1;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			bad = 1'b1;
		end
		if (bad) mismatches++;
	endtask

	// scoreboard: result beats first, then predict the accepted input beat
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					$error("unexpected result beat %p", out_data);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					check_report(want, out_data);
				end
			end
			if (in_valid && in_ready) begin
				advance_watchdog(in_data);
				if (row_typed) pending_reports[pending_reports.size() - 1] = row_status;
			end
		end
	end

	// result side backpressure, alternating calm and stalling stretches
	always @(posedge clk) begin
		int gap;
		if (rx_mode_left == 0) begin
			rx_calm      = ($urandom_range(0, 3) == 0);
			rx_mode_left = $urandom_range(50, 300);
		end
		rx_mode_left--;
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else begin
			gap = pick_gap(rx_calm);
			if (gap > 0) begin
				rx_hold = gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_item(input in_item_t it, input bit typed, input out_item_t st);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		in_data    <= it;
		row_typed  <= typed;
		row_status <= st;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results(input int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TIMEOUT: timeout_r = data;
			CFG_ESC:     esc_r     = data[7:0];
			CFG_RESTART: restart_r = data[7:0];
			CFG_REINIT:  reinit_r  = data[7:0];
			CFG_EXEMPT:  exempt_r  = data[7:0];
			default: ;
		endcase
	endtask

	// 8-bit registers get junk in the upper bits, which must be dropped
	task automatic program_watchdog(input watch_setting_t s);
		cfg_write(CFG_TIMEOUT, s.timeout);
		cfg_write(CFG_ESC, {24'($urandom), s.esc});
		cfg_write(CFG_RESTART, {24'($urandom), s.restart});
		cfg_write(CFG_REINIT, {24'($urandom), s.reinit});
		cfg_write(CFG_EXEMPT, {24'($urandom), s.exempt});
		cfg_write(3'($urandom_range(CFG_EXEMPT + 1, CFG_SLOTS - 1)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic next_random_item(input bit saturate, inout logic [31:0] now,
			output in_item_t it);
		int r;
		r = $urandom_range(0, 99);
		it.kind    = KIND_SCAN;
		it.channel = CH_W'($urandom);
		it.tick    = now;
		if (saturate) begin
			// channel 0 never beats here, so it escalates on every scan
			if (r < 8) begin
				it.kind    = KIND_BEAT;
				it.channel = CH_W'($urandom_range(1, 7));
			end else if (r < 50) begin
				now     = $urandom_range(2, 32'hFFFF_FFFF);
				it.tick = now;
			end
		end else if (r < 30) begin
			it.kind    = KIND_BEAT;
			it.channel = (r < 27) ? CH_W'($urandom_range(0, CHANNELS - 1))
				: CH_W'($urandom_range(CHANNELS, 7));
			if (r >= 24) it.tick = $urandom;
		end else if (r < 88) begin
			now     = now + $urandom_range(0, timeout_r / 2 + 2);
			it.tick = now;
		end else if (r < 92) begin
			it.tick = $urandom;
		end else begin
			it.kind    = 1'($urandom_range(0, 1));
			it.channel = CH_W'($urandom_range(0, 7));
			it.tick    = $urandom;
		end
	endtask

	initial begin
		stim_row_t      directed_rows [$];
		watch_setting_t plan [5];
		in_item_t       it;
		logic [31:0]    now;

		// reset config: timeout 3000, escalate at 3, channels 3 and 4 exempt
		directed_rows.push_back(checked_scan(32'd0, ST_HEALTHY, 8'h00));
		directed_rows.push_back(beat_row(3'd0, 32'd100));
		directed_rows.push_back(beat_row(3'd1, 32'd0));
		directed_rows.push_back(beat_row(3'd3, 32'd100));
		directed_rows.push_back(beat_row(3'd7, 32'hFFFF_FFFF));
		directed_rows.push_back(beat_row(3'd6, 32'd7));
		directed_rows.push_back(checked_scan(32'd3100, ST_HEALTHY, 8'h00));
		directed_rows.push_back(checked_scan(32'd3101, ST_HEALTHY, 8'h01));
		directed_rows.push_back(checked_scan(32'd3102, ST_HEALTHY, 8'h01));
		directed_rows.push_back(scan_row(32'd3103));
		directed_rows.push_back(checked_scan(32'd3104, ST_NERVOUS, 8'h01));
		directed_rows.push_back(checked_scan(32'd3105, ST_NERVOUS, 8'h01));
		directed_rows.push_back(scan_row(32'd3106));
		directed_rows.push_back(scan_row(32'd3107));
		directed_rows.push_back(scan_row(32'd3108));
		directed_rows.push_back(scan_row(32'd3109));
		directed_rows.push_back(beat_row(3'd0, 32'd4000));
		directed_rows.push_back(checked_scan(32'd4001, ST_CRITICAL, 8'h00));
		directed_rows.push_back(beat_row(3'd2, 32'hFFFF_FFF0));
		directed_rows.push_back(beat_row(3'd5, 32'hFFFF_FFFF));
		directed_rows.push_back(checked_scan(32'd5, ST_CRITICAL, 8'h01));
		directed_rows.push_back(beat_row(3'd1, 32'd1));
		directed_rows.push_back(scan_row(32'hFFFF_FFFF));

		plan[0] = '{32'd40, 8'd2, 8'd1, 8'd3, 8'h00, 20, 1'b0};
		plan[1] = '{32'd1, 8'd1, 8'd0, 8'd0, 8'h25, 14, 1'b0};
		plan[2] = '{32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 8'hFF, 6, 1'b0};
		plan[3] = '{32'd500, 8'd4, 8'd2, 8'd4, 8'h12, 16, 1'b0};
		plan[4] = '{32'd0, 8'd0, 8'd3, 8'd150, 8'h00, 180, 1'b1};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].status);

		now = 32'hFFFF_FF00;
		foreach (plan[p]) begin
			drain_results(SETTLE_CYCLES);
			program_watchdog(plan[p]);
			if (plan[p].saturate) begin
				now = $urandom_range(2, 32'hFFFF_FFFF);
				send_item('{kind: KIND_BEAT, channel: '0, tick: 32'd1}, 1'b0, '0);
			end
			for (int n = 0; n < plan[p].items; n++) begin
				if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
				if ($urandom_range(0, 29) == 0) drain_results(0);
				next_random_item(plan[p].saturate, now, it);
				send_item(it, 1'b0, '0);
			end
		end

		drain_results(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
